// ===== hw/rtl/lfu_pkg.sv =====
package lfu_pkg;

    // Live entries never exceed ENTRIES once a request is finished; one spare
    // slot holds the new entry of an insert into a full store.
    localparam int ENTRIES = 16;
    localparam int SLOTS   = ENTRIES + 1;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = 5;
    localparam int VAL_W   = 32;
    localparam int USE_W   = 16;

    localparam logic [USE_W-1:0] USE_MAX   = '1;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(ENTRIES);

    typedef struct packed {
        logic load_req;   // capture request, clear result
        logic ptr_clr;    // read pointer to slot 0
        logic ptr_victim; // read pointer to the slot after the victim
        logic issue;      // read the slot at the pointer, advance pointer
        logic hit_wb;     // write back raised use count, record hit
        logic ins_wr;     // append new entry, bump count
        logic min_track;  // follow the smallest use count
        logic shift;      // move returned entry one slot down
        logic cnt_dec;    // drop one entry from the count
    } lfu_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic ptr_lt_cnt;
        logic pv;
        logic match;
        logic last;
        logic over_lim;
    } lfu_sts_t;

endpackage

// ===== hw/rtl/lfu_dp.sv =====
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int KEY_BITS = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfu_cmd_t            cmd,
    output lfu_sts_t            sts,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [VAL_W-1:0]    s_value,
    input  logic [CNT_W-1:0]    cap,
    output logic                res_hit,
    output logic [VAL_W-1:0]    res_value,
    output logic [CNT_W-1:0]    res_occ
);

    localparam int W = KEY_BITS + VAL_W + USE_W;

    // entry word: {use count, value, key}
    logic [W-1:0]        mem [SLOTS];
    logic [W-1:0]        rd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    prev_reg;
    logic                pv_reg;
    logic [USE_W-1:0]    min_reg;
    logic [IDX_W-1:0]    victim_reg;
    logic                hit_reg;
    logic [VAL_W-1:0]    hval_reg;

    logic [KEY_BITS-1:0] rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic [USE_W-1:0]    rd_use;
    logic [USE_W-1:0]    use_inc;
    logic [CNT_W-1:0]    lim;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [W-1:0]        wdata;

    assign rd_key  = rd_reg[KEY_BITS-1:0];
    assign rd_val  = rd_reg[KEY_BITS +: VAL_W];
    assign rd_use  = rd_reg[KEY_BITS+VAL_W +: USE_W];
    assign use_inc = (rd_use == USE_MAX) ? rd_use : rd_use + 1'b1;
    assign lim     = (cap > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cap;

    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.ptr_lt_cnt = (CNT_W'(ptr_reg) < cnt_reg);
    assign sts.pv         = pv_reg;
    assign sts.match      = pv_reg && (rd_key == key_reg);
    assign sts.last       = pv_reg && ((CNT_W'(prev_reg) + 1'b1) == cnt_reg);
    assign sts.over_lim   = (cnt_reg > lim);

    assign res_hit   = hit_reg;
    assign res_value = hval_reg;
    assign res_occ   = cnt_reg;

    always_comb begin
        we    = 1'b0;
        waddr = prev_reg;
        wdata = rd_reg;
        priority if (cmd.ins_wr) begin
            we    = 1'b1;
            waddr = cnt_reg[IDX_W-1:0];
            wdata = {USE_W'(0), val_reg, key_reg};
        end else if (cmd.hit_wb) begin
            we    = 1'b1;
            wdata = {use_inc, rd_val, rd_key};
        end else if (cmd.shift && pv_reg) begin
            we    = 1'b1;
            waddr = prev_reg - 1'b1;
        end else begin
            we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        prev_reg <= ptr_reg;
        if (cmd.load_req) begin
            key_reg  <= s_key;
            val_reg  <= s_value;
            hval_reg <= '0;
        end else if (cmd.hit_wb) begin
            hval_reg <= rd_val;
        end
        if (cmd.min_track && pv_reg && (prev_reg == '0 || rd_use < min_reg)) begin
            min_reg    <= rd_use;
            victim_reg <= prev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
            pv_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.issue;
            priority if (cmd.ptr_clr) begin
                ptr_reg <= '0;
            end else if (cmd.ptr_victim) begin
                ptr_reg <= victim_reg + 1'b1;
            end else if (cmd.issue) begin
                ptr_reg <= ptr_reg + 1'b1;
            end else begin
                ptr_reg <= ptr_reg;
            end
            if (cmd.ins_wr) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.load_req) begin
                hit_reg <= 1'b0;
            end else if (cmd.hit_wb) begin
                hit_reg <= 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("entry count beyond store depth");

    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift && pv_reg) |-> (prev_reg != '0))
        else $error("compaction writes below slot 0");

    a_ins_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("insert did not grow the store");

endmodule

// ===== hw/rtl/lfu_ctrl.sv =====
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_req,
    output logic     s_ready,
    input  logic     out_free,
    output logic     out_load,
    output lfu_cmd_t cmd,
    input  lfu_sts_t sts
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LK_SCAN  = 3'd1;
    localparam logic [2:0] ST_INS_WR   = 3'd2;
    localparam logic [2:0] ST_EV_CHK   = 3'd3;
    localparam logic [2:0] ST_EV_SCAN  = 3'd4;
    localparam logic [2:0] ST_EV_PRE   = 3'd5;
    localparam logic [2:0] ST_EV_SHIFT = 3'd6;
    localparam logic [2:0] ST_RESULT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        out_load   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    cmd.ptr_clr  = 1'b1;
                    state_next   = s_req ? ST_INS_WR : ST_LK_SCAN;
                end
            end
            ST_LK_SCAN: begin
                cmd.issue = sts.ptr_lt_cnt;
                priority if (sts.match) begin
                    cmd.hit_wb = 1'b1;
                    state_next = ST_RESULT;
                end else if (sts.last || sts.cnt_zero) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_LK_SCAN;
                end
            end
            ST_INS_WR: begin
                cmd.ins_wr = 1'b1;
                state_next = ST_EV_CHK;
            end
            ST_EV_CHK: begin
                if (sts.over_lim) begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_EV_SCAN;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_EV_SCAN: begin
                cmd.issue     = sts.ptr_lt_cnt;
                cmd.min_track = 1'b1;
                if (sts.last) begin
                    state_next = ST_EV_PRE;
                end
            end
            ST_EV_PRE: begin
                cmd.ptr_victim = 1'b1;
                state_next     = ST_EV_SHIFT;
            end
            ST_EV_SHIFT: begin
                cmd.issue = sts.ptr_lt_cnt;
                cmd.shift = 1'b1;
                if (!sts.ptr_lt_cnt && !sts.pv) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_EV_CHK;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/lfu_cache_policy.sv =====
// LFU cache policy: fully associative store of up to 16 entries kept in
// insertion order, with least-frequently-used eviction.
// Input stream (s_*): one request per transfer; s_tuser is the request kind
// (0 lookup, 1 insert), s_tdata carries key and insert value.
// Output stream (m_*): exactly one result transfer per request, in order;
// m_tuser is the hit flag, m_tdata carries the value and the occupancy.
// APB port: one register, capacity_limit at address 0; write it only while
// no request is in flight.
// Timing: one request at a time. A lookup walks the store one entry per
// cycle through the single read port of the entry memory, stopping at the
// first match or after the last live entry. An insert appends the new entry;
// each eviction then scans the live entries for the least used one and
// closes the gap by moving every entry above it one slot down.
// A finished result sits in the output register; s_tready rises again as
// soon as the result is loaded there, so the next request is taken while the
// receiver still holds off. If m_tready stays low, the following result waits
// in the controller and no further request is taken.
// Reset (aresetn, synchronous, low): store empty, limit 16, no result
// pending. Entry contents are not cleared; only reads of live slots are used.
module lfu_cache_policy
    import lfu_pkg::*;
#(
    parameter int KEY_BITS = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [KEY_BITS-1:0] key, [KEY_BITS+31:KEY_BITS] value_in, zero padding above
    input  logic [((KEY_BITS+VAL_W+7)/8)*8-1:0] s_tdata,
    // [0] req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] value_out, [36:32] occupancy, [39:37] zero
    output logic [((VAL_W+CNT_W+7)/8)*8-1:0] m_tdata,
    // [0] hit
    output logic                    m_tuser,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int  M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
    localparam logic REG_CAP  = 1'b0;

    lfu_cmd_t         cmd;
    lfu_sts_t         sts;
    logic             out_free;
    logic             out_load;
    logic             res_hit;
    logic [VAL_W-1:0] res_value;
    logic [CNT_W-1:0] res_occ;

    logic [CNT_W-1:0] cap_reg;
    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [VAL_W-1:0] m_val_reg;
    logic [CNT_W-1:0] m_occ_reg;

    // config register: word select on paddr[2], byte offset ignored
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP) ? 32'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAP) begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_req    (s_tuser),
        .s_ready  (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .sts      (sts)
    );

    lfu_dp #(
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_key     (s_tdata[KEY_BITS-1:0]),
        .s_value   (s_tdata[KEY_BITS +: VAL_W]),
        .cap       (cap_reg),
        .res_hit   (res_hit),
        .res_value (res_value),
        .res_occ   (res_occ)
    );

    // output register: free when empty or drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_reg <= res_hit;
            m_val_reg <= res_value;
            m_occ_reg <= res_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {(M_TDATA_W - VAL_W - CNT_W)'(0), m_occ_reg, m_val_reg};

endmodule

// ===== bench/lfu_cache_policy_test.sv =====
module lfu_cache_policy_test;
    import lfu_pkg::*;

    // Bus geometry, as laid out at the block's ports
    localparam int KEY_W = 48;
    localparam int S_W   = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_W   = ((VAL_W + CNT_W + 7) / 8) * 8;

    // Register map: capacity_limit is register 0; address 4 is an unused slot
    localparam logic [2:0] ADDR_CAP_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;

    // Run shaping
    localparam int POOL_SIZE   = 24;      // keys that random traffic keeps reusing
    localparam int PHASE_ITEMS = 77;
    localparam int PHASES      = 6;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the block
    localparam int SETTLE_GAP  = 6;       // idle cycles before a register write
    localparam int END_WAIT    = 50;
    localparam int QUIET_LIMIT = 5000;    // cycles with no transfer anywhere
    localparam int HOT_HITS    = 12;      // lifts one use count well above the rest
    localparam int PRINT_CAP   = 40;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_INSERT = 1'b1
    } req_kind_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready one cycle in four
        RX_COMB      // fixed on/off comb
    } rx_mode_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] occ;
    } reply_t;

    typedef struct {
        reply_t want;
        bit     typed;
        reply_t typed_want;
    } due_t;

    typedef struct {
        row_kind_t        kind;
        req_kind_t        req;
        logic [KEY_W-1:0] key;
        logic [31:0]      data;    // value_in, or register data on a config row
        logic [2:0]       addr;
        bit               typed;
        reply_t           want;
    } stim_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;     // [47:0] key, [79:48] value_in
    logic             s_tuser;     // [0] req_type
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;     // [31:0] value_out, [36:32] occupancy, [39:37] zero
    logic             m_tuser;     // [0] hit
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    lfu_cache_policy #(.KEY_BITS(KEY_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the cache: insertion order, oldest at slot 0, one spare slot
    logic [KEY_W-1:0] shadow_key [SLOTS];
    logic [VAL_W-1:0] shadow_val [SLOTS];
    logic [USE_W-1:0] shadow_use [SLOTS];
    int               shadow_fill  = 0;
    logic [CNT_W-1:0] shadow_limit = CAP_RESET;

    due_t             answers_due[$];
    stim_row_t        plan[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // Handshake counters, bumped at the rising edge, read by the drivers at the falling edge
    int          in_taken  = 0;
    int          out_taken = 0;
    int          cfg_taken = 0;
    logic [31:0] rd_value  = '0;

    // What the driver is currently offering alongside s_tdata
    bit     row_typed;
    reply_t row_want;

    int errors = 0;
    int n_lookup = 0, n_hit = 0, n_insert = 0;
    int n_settings;
    int burst_left;
    int hold_asks;
    int hold_done = 0;
    int quiet = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < PRINT_CAP)
            $display("MISMATCH after %0d results: %s got 0x%0h, expected 0x%0h",
                     out_taken, what, got, want);
        errors++;
    endtask

    task automatic check_reply(reply_t got, reply_t want, string src);
        if (got.hit !== want.hit)
            flag_mismatch({src, " hit"}, 64'(got.hit), 64'(want.hit));
        if (got.value !== want.value)
            flag_mismatch({src, " value_out"}, 64'(got.value), 64'(want.value));
        if (got.occ !== want.occ)
            flag_mismatch({src, " occupancy"}, 64'(got.occ), 64'(want.occ));
    endtask

    // Works one request through the shadow cache and returns the reply it gives
    function automatic reply_t cache_answer(req_kind_t kind, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
        reply_t r;
        int     i;
        int     lim;
        int     victim;
        bit     found;
        r = '0;
        found = 1'b0;
        if (kind == REQ_LOOKUP) begin
            for (i = 0; i < shadow_fill; i++) begin
                if (!found && shadow_key[i] == key) begin
                    found = 1'b1;
                    r.hit = 1'b1;
                    r.value = shadow_val[i];
                    if (shadow_use[i] != USE_MAX)
                        shadow_use[i] = shadow_use[i] + 1'b1;
                end
            end
        end else begin
            // limits above the store size act as a full store
            lim = (shadow_limit > ENTRIES) ? ENTRIES : int'(shadow_limit);
            shadow_key[shadow_fill] = key;
            shadow_val[shadow_fill] = val;
            shadow_use[shadow_fill] = '0;
            shadow_fill++;
            // oldest among the least used goes first; may be the newcomer
            while (shadow_fill > lim) begin
                victim = 0;
                for (i = 1; i < shadow_fill; i++)
                    if (shadow_use[i] < shadow_use[victim])
                        victim = i;
                for (i = victim; i + 1 < shadow_fill; i++) begin
                    shadow_key[i] = shadow_key[i + 1];
                    shadow_val[i] = shadow_val[i + 1];
                    shadow_use[i] = shadow_use[i + 1];
                end
                shadow_fill--;
            end
        end
        r.occ = CNT_W'(shadow_fill);
        return r;
    endfunction

    // Monitor: results are checked before the same edge's request is predicted;
    // the block runs one request at a time, so a result never belongs to a
    // request taken on the same edge.
    always @(posedge aclk) begin
        due_t   d;
        reply_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.hit   = m_tuser;
                got.value = m_tdata[VAL_W-1:0];
                got.occ   = m_tdata[VAL_W+CNT_W-1:VAL_W];
                if (answers_due.size() == 0) begin
                    flag_mismatch("result with no request waiting", 64'(got), 64'd0);
                end else begin
                    d = answers_due.pop_front();
                    check_reply(got, d.want, "predicted");
                    if (d.typed)
                        check_reply(got, d.typed_want, "directed");
                end
                if (got.hit)
                    n_hit++;
                out_taken <= out_taken + 1;
            end
            if (s_tvalid && s_tready) begin
                d.want = cache_answer(req_kind_t'(s_tuser), s_tdata[KEY_W-1:0],
                                      s_tdata[KEY_W+VAL_W-1:KEY_W]);
                d.typed = row_typed;
                d.typed_want = row_want;
                answers_due = {answers_due, d};
                if (s_tuser == REQ_INSERT)
                    n_insert++;
                else
                    n_lookup++;
                in_taken <= in_taken + 1;
            end
            if (psel && penable && pready) begin
                if (pwrite && paddr == ADDR_CAP_LIMIT)
                    shadow_limit = pwdata[CNT_W-1:0];
                if (!pwrite)
                    rd_value <= prdata;
                cfg_taken <= cfg_taken + 1;
            end
        end
    end

    // Watchdog: any transfer on either stream or the register port resets it
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Timed out: no transfer for %0d cycles, %0d results outstanding",
                     quiet, answers_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: switches between stall patterns; honours hold-off requests
    initial begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = hold_asks;
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                default:   m_tready = ((left % 5) < 2);
            endcase
        end
    end

    // Offer one request and hold it until the block takes it
    task automatic offer(req_kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                         bit typed = 1'b0, reply_t want = '0);
        int seen;
        seen = in_taken;
        s_tvalid  = 1'b1;
        s_tuser   = kind;
        s_tdata   = S_W'({val, key});
        row_typed = typed;
        row_want  = want;
        do @(negedge aclk); while (in_taken == seen);
    endtask

    // Sender pacing: bursts of random length, random gaps, now and then a long run
    task automatic pace();
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Wait for the block to go idle: every result back, then a short margin
    task automatic settle();
        s_tvalid = 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_GAP) @(negedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
        int seen;
        seen    = cfg_taken;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(negedge aclk); while (cfg_taken == seen);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Register write while idle, then read the limit back
    task automatic set_register(logic [2:0] addr, logic [31:0] data);
        settle();
        apb_access(1'b1, addr, data);
        apb_access(1'b0, ADDR_CAP_LIMIT, 32'd0);
        if (rd_value[CNT_W-1:0] !== shadow_limit)
            flag_mismatch("capacity_limit readback", 64'(rd_value), 64'(shadow_limit));
        n_settings++;
    endtask

    task automatic req_row(req_kind_t req, logic [KEY_W-1:0] key, logic [31:0] val,
                           bit typed, logic hit, logic [31:0] value, int occ);
        stim_row_t r;
        r.kind      = ROW_REQ;
        r.req       = req;
        r.key       = key;
        r.data      = val;
        r.addr      = ADDR_CAP_LIMIT;
        r.typed     = typed;
        r.want.hit  = hit;
        r.want.value = value;
        r.want.occ  = CNT_W'(occ);
        plan = {plan, r};
    endtask

    task automatic cfg_row(logic [2:0] addr, logic [31:0] data);
        stim_row_t r;
        r.kind  = ROW_CFG;
        r.req   = REQ_LOOKUP;
        r.key   = '0;
        r.data  = data;
        r.addr  = addr;
        r.typed = 1'b0;
        r.want  = '0;
        plan = {plan, r};
    endtask

    initial begin
        logic [63:0]      wide;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] pick_a, pick_b, pick_c;
        int               phase_limit [PHASES];
        int               p, n;
        req_kind_t        kind;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        row_typed = 1'b0;
        row_want  = '0;
        n_settings = 0;
        burst_left = 0;
        hold_asks = 0;

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows; the reply is typed in where it is obvious
        req_row(REQ_LOOKUP, '0, '0, 1, 0, '0, 0);                      // empty store
        req_row(REQ_INSERT, '1, '1, 1, 0, '0, 1);                      // all-ones key/value
        req_row(REQ_LOOKUP, '1, '0, 1, 1, '1, 1);
        req_row(REQ_INSERT, '0, '0, 1, 0, '0, 2);                      // all-zero key/value
        req_row(REQ_LOOKUP, '0, '0, 1, 1, '0, 2);
        req_row(REQ_LOOKUP, 48'd1, '0, 1, 0, '0, 2);
        req_row(REQ_INSERT, '0, 32'h1234_5678, 1, 0, '0, 3);           // duplicate key
        req_row(REQ_LOOKUP, '0, '0, 1, 1, '0, 3);                      // first match wins
        req_row(REQ_LOOKUP, 48'h8000_0000_0000, '0, 1, 0, '0, 3);
        req_row(REQ_LOOKUP, '1, 32'hDEAD_BEEF, 1, 1, '1, 3);           // value_in ignored
        cfg_row(ADDR_CAP_LIMIT, 32'd2);                                // lowered below occupancy
        req_row(REQ_LOOKUP, '0, '0, 1, 1, '0, 3);                      // nothing evicted yet
        req_row(REQ_INSERT, 48'd5, 32'd5, 1, 0, '0, 2);                // evicts dup, then itself
        req_row(REQ_LOOKUP, 48'd5, '0, 1, 0, '0, 2);
        cfg_row(ADDR_CAP_LIMIT, 32'd0);                                // limit of zero
        req_row(REQ_INSERT, 48'd7, 32'd7, 1, 0, '0, 0);
        req_row(REQ_LOOKUP, '1, '0, 1, 0, '0, 0);
        cfg_row(ADDR_CAP_LIMIT, 32'd31);                               // above store size
        cfg_row(ADDR_SPARE, 32'd1);                                    // unmapped, ignored
        req_row(REQ_INSERT, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1, 0, '0, 1);
        req_row(REQ_LOOKUP, 48'hAAAA_AAAA_AAAA, '0, 1, 1, 32'h5555_5555, 1);
        cfg_row(ADDR_CAP_LIMIT, 32'd16);
        cfg_row(ADDR_CAP_LIMIT, 32'd1);
        req_row(REQ_INSERT, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1, 0, '0, 1); // newcomer evicted
        req_row(REQ_LOOKUP, 48'h5555_5555_5555, '0, 1, 0, '0, 1);
        req_row(REQ_LOOKUP, 48'hAAAA_AAAA_AAAA, '0, 1, 1, 32'h5555_5555, 1);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                set_register(plan[i].addr, plan[i].data);
            end else begin
                pace();
                offer(plan[i].req, plan[i].key, plan[i].data, plan[i].typed, plan[i].want);
            end
        end

        // Eviction by use count: A is looked up often, B a few times. With the
        // limit then at 1, an insert must evict the newcomer, the older entry
        // and then B, leaving A.
        wide   = {$urandom, $urandom};
        pick_a = wide[KEY_W-1:0];
        pick_b = ~pick_a;
        pick_c = pick_a ^ 48'h0000_0100_0000;
        set_register(ADDR_CAP_LIMIT, 32'd16);
        offer(REQ_INSERT, pick_a, $urandom);
        offer(REQ_INSERT, pick_b, $urandom);
        repeat (HOT_HITS) offer(REQ_LOOKUP, pick_a, $urandom);
        repeat (4) offer(REQ_LOOKUP, pick_b, $urandom);
        set_register(ADDR_CAP_LIMIT, 32'd1);
        offer(REQ_INSERT, pick_c, $urandom);
        offer(REQ_LOOKUP, pick_a, '0);
        offer(REQ_LOOKUP, pick_b, '0);
        offer(REQ_LOOKUP, pick_c, '0);

        // Key pool: random keys plus near neighbours differing in a single bit
        for (n = 0; n < POOL_SIZE; n++) begin
            wide = {$urandom, $urandom};
            if (n < 16)
                key_pool[n] = wide[KEY_W-1:0];
            else
                key_pool[n] = key_pool[n - 16] ^ (48'd1 << $urandom_range(0, KEY_W - 1));
        end

        phase_limit[0] = 31;
        phase_limit[1] = 4;
        phase_limit[2] = 1;
        phase_limit[3] = 16;                        // receiver hold-off falls in here
        phase_limit[4] = 0;
        phase_limit[5] = $urandom_range(2, 15);

        for (p = 0; p < PHASES; p++) begin
            set_register(ADDR_CAP_LIMIT, 32'(phase_limit[p]));
            if (p == 3)
                hold_asks++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pace();
                kind = ($urandom_range(0, 99) < 35) ? REQ_INSERT : REQ_LOOKUP;
                if ($urandom_range(0, 9) == 0) begin
                    wide = {$urandom, $urandom};
                    key  = wide[KEY_W-1:0];
                end else begin
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                offer(kind, key, $urandom);
            end
        end

        settle();
        repeat (END_WAIT) @(negedge aclk);

        $display("Run covered %0d lookups (%0d hits) and %0d inserts over %0d register writes,",
                 n_lookup, n_hit, n_insert, n_settings);
        $display("limits 0 to 31, duplicate keys, self-eviction and count-ordered eviction.");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, answers_due.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_dp.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_cache_policy.sv
bench/lfu_cache_policy_test.sv
